>>> design/rrct_pkg.sv
// Shared types, constants and the control store for the round-robin completion-time block.
// No dependencies; used by rrct_seq, rrct_dp and round_robin_completion_times_core.
`default_nettype none
package rrct_pkg;

	localparam int MaxProcs = 16;
	localparam int IdxW     = $clog2(MaxProcs);
	localparam int CntW     = $clog2(MaxProcs + 1);
	localparam int BurstW   = 16;
	localparam int RemW     = 17;
	localparam int QuantW   = 10;
	localparam int TimeW    = 21;
	localparam int IdW      = 5;
	localparam int PcW      = 3;
	localparam int CondW    = 3;

	localparam logic [QuantW-1:0] QUANTUM_RESET = QuantW'(10);
	localparam logic [TimeW-1:0]  TIME_MAX      = {TimeW{1'b1}};

	// Register map (byte address divided by four).
	localparam logic REG_QUANTUM = 1'b0;

	// Jump conditions.
	localparam logic [CondW-1:0] COND_ALWAYS    = 3'd0;
	localparam logic [CondW-1:0] COND_NOT_START = 3'd1;
	localparam logic [CondW-1:0] COND_CNT_ZERO  = 3'd2;
	localparam logic [CondW-1:0] COND_NOT_LIVE  = 3'd3;
	localparam logic [CondW-1:0] COND_REM_POS   = 3'd4;
	localparam logic [CondW-1:0] COND_OUT_BUSY  = 3'd5;
	localparam logic [CondW-1:0] COND_LIVE_ANY  = 3'd6;

	// Program steps.
	localparam logic [PcW-1:0] STEP_IDLE    = 3'd0;
	localparam logic [PcW-1:0] STEP_INIT    = 3'd1;
	localparam logic [PcW-1:0] STEP_VISIT   = 3'd2;
	localparam logic [PcW-1:0] STEP_CHECK   = 3'd3;
	localparam logic [PcW-1:0] STEP_EMIT    = 3'd4;
	localparam logic [PcW-1:0] STEP_ADVANCE = 3'd5;
	localparam logic [PcW-1:0] STEP_FINISH  = 3'd6;

	typedef struct packed {
		logic             in_ready;
		logic             op_init;
		logic             op_visit;
		logic             op_emit;
		logic             op_advance;
		logic             op_finish;
		logic [CondW-1:0] cond;
		logic [PcW-1:0]   target;
	} ctrl_word_t;

	typedef struct packed {
		logic start;
		logic cnt_zero;
		logic cur_live;
		logic rem_pos;
		logic out_busy;
		logic live_any;
	} dp_status_t;

	// Control store. When the condition holds the step counter jumps to the
	// target, otherwise it moves on to the next step.
	function automatic ctrl_word_t ctrl_rom(input logic [PcW-1:0] pc);
		ctrl_word_t w;
		w = '0;
		case (pc)
			STEP_IDLE: begin
				w.in_ready = 1'b1;
				w.cond     = COND_NOT_START;
				w.target   = STEP_IDLE;
			end
			STEP_INIT: begin
				w.op_init = 1'b1;
				w.cond    = COND_CNT_ZERO;
				w.target  = STEP_FINISH;
			end
			STEP_VISIT: begin
				w.op_visit = 1'b1;
				w.cond     = COND_NOT_LIVE;
				w.target   = STEP_ADVANCE;
			end
			STEP_CHECK: begin
				w.cond   = COND_REM_POS;
				w.target = STEP_ADVANCE;
			end
			STEP_EMIT: begin
				w.op_emit = 1'b1;
				w.cond    = COND_OUT_BUSY;
				w.target  = STEP_EMIT;
			end
			STEP_ADVANCE: begin
				w.op_advance = 1'b1;
				w.cond       = COND_LIVE_ANY;
				w.target     = STEP_VISIT;
			end
			STEP_FINISH: begin
				w.op_finish = 1'b1;
				w.cond      = COND_ALWAYS;
				w.target    = STEP_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> design/rrct_seq.sv
// Step counter and condition select of the microcoded sequencer.
// Depends on rrct_pkg for the control store and the status and control types.
`default_nettype none
module rrct_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rrct_pkg::dp_status_t status,
	output rrct_pkg::ctrl_word_t ctrl
);
	import rrct_pkg::*;

	logic [PcW-1:0] pc_q;
	logic           take;

	assign ctrl = ctrl_rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			COND_ALWAYS:    take = 1'b1;
			COND_NOT_START: take = !status.start;
			COND_CNT_ZERO:  take = status.cnt_zero;
			COND_NOT_LIVE:  take = !status.cur_live;
			COND_REM_POS:   take = status.rem_pos;
			COND_OUT_BUSY:  take = status.out_busy;
			COND_LIVE_ANY:  take = status.live_any;
			default:        take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PcW'(1);
		end
	end

endmodule
`default_nettype wire

>>> design/rrct_dp.sv
// Datapath: remaining-time store, live mask, serve pointer, elapsed time and result register.
// Depends on rrct_pkg; driven by the control word from rrct_seq.
`default_nettype none
module rrct_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rrct_pkg::ctrl_word_t         ctrl,
	output rrct_pkg::dp_status_t         status,
	input  wire [rrct_pkg::QuantW-1:0]   quantum_eff,
	input  wire                          in_valid,
	input  wire [rrct_pkg::BurstW-1:0]   in_burst,
	input  wire                          in_last,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [rrct_pkg::IdW-1:0]     out_id,
	output logic [rrct_pkg::TimeW-1:0]   out_time,
	output logic                         out_drop,
	output logic                         out_last
);
	import rrct_pkg::*;

	logic signed [RemW-1:0] rem_mem [MaxProcs];
	logic [MaxProcs-1:0]    live_q;
	logic [CntW-1:0]        count_q;
	logic [IdxW-1:0]        ptr_q;
	logic [TimeW-1:0]       elapsed_q;
	logic                   drop_q;

	logic                   load;
	logic signed [RemW-1:0] rem_cur;
	logic signed [RemW-1:0] rem_sub;
	logic [TimeW:0]         elapsed_sum;
	logic [MaxProcs-1:0]    ptr_bit;
	logic [MaxProcs-1:0]    live_init;
	logic                   cur_live;
	logic                   rem_pos;
	logic                   out_busy;
	logic                   do_visit;
	logic                   do_emit;
	logic [CntW-1:0]        ptr_next;

	assign load     = ctrl.in_ready && in_valid;
	assign rem_cur  = rem_mem[ptr_q];
	assign rem_sub  = rem_cur - $signed({{(RemW-QuantW){1'b0}}, quantum_eff});
	assign elapsed_sum = {1'b0, elapsed_q} + (TimeW+1)'(quantum_eff);
	assign ptr_bit  = MaxProcs'(1) << ptr_q;
	assign cur_live = |(live_q & ptr_bit);
	assign rem_pos  = rem_cur > 0;
	assign out_busy = out_valid && !out_ready;
	assign do_visit = ctrl.op_visit && cur_live && rem_pos;
	assign do_emit  = ctrl.op_emit && !out_busy;
	assign ptr_next = CntW'(ptr_q) + CntW'(1);

	always_comb begin
		for (int k = 0; k < MaxProcs; k++) begin
			live_init[k] = CntW'(k) < count_q;
		end
	end

	assign status.start    = load && in_last;
	assign status.cnt_zero = count_q == '0;
	assign status.cur_live = cur_live;
	assign status.rem_pos  = rem_pos;
	assign status.out_busy = out_busy;
	assign status.live_any = |live_q;

	// Remaining times have no reset; only loaded entries are ever visited.
	always_ff @(posedge clk) begin
		if (load && count_q < CntW'(MaxProcs)) begin
			rem_mem[count_q[IdxW-1:0]] <= $signed({1'b0, in_burst});
		end else if (do_visit) begin
			rem_mem[ptr_q] <= rem_sub;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			elapsed_q <= '0;
			drop_q    <= 1'b0;
		end else begin
			if (load) begin
				if (count_q < CntW'(MaxProcs)) begin
					count_q <= count_q + CntW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (ctrl.op_init) begin
				live_q    <= live_init;
				ptr_q     <= '0;
				elapsed_q <= '0;
			end
			if (do_visit) begin
				elapsed_q <= elapsed_sum[TimeW] ? TIME_MAX : elapsed_sum[TimeW-1:0];
			end
			if (do_emit) begin
				live_q <= live_q & ~ptr_bit;
			end
			if (ctrl.op_advance) begin
				ptr_q <= (ptr_next < count_q) ? ptr_next[IdxW-1:0] : '0;
			end
			if (ctrl.op_finish) begin
				live_q  <= '0;
				count_q <= '0;
				ptr_q   <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	// Result register: the sequencer waits on the emit step while it is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (do_emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_id   <= IdW'(ptr_q) + IdW'(1);
			out_time <= elapsed_q;
			out_drop <= drop_q;
			out_last <= (live_q & ~ptr_bit) == '0;
		end
	end

endmodule
`default_nettype wire

>>> design/round_robin_completion_times_core.sv
// Top level of the round-robin completion-time block: register port, sequencer and datapath.
// Depends on rrct_pkg, rrct_seq and rrct_dp.
`default_nettype none
// Burst times stream in on the slave side, one transaction per cycle, and are stored as
// processes 1 to 16 in arrival order; further loads are dropped and reported through the
// overflowed bit. The transaction with tlast set is handled the same way and starts a round-robin run,
// during which no input is taken. A short microprogram walks the stored processes over a
// single datapath: a visit to a live process runs the visit, check and advance steps, a
// completion adds an emit step to deliver its result, a visit to a finished slot runs the
// visit and advance steps only, and the run opens with init and closes with finish. Results
// leave in completion order through an output register, with tlast on the final completion;
// the walk stalls only when a result is waiting in that register. Quantum lies at byte
// address 0; a value of zero acts as one. Write it only while the block is idle.
module round_robin_completion_times_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [15:0] burst_time
	input  wire         s_tlast,   // last_item
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [4:0] process_id, [25:5] completion_time, [26] overflowed
	output logic        m_tlast    // last_done
);
	import rrct_pkg::*;

	logic [QuantW-1:0] quantum_q;
	logic [QuantW-1:0] quantum_eff;
	ctrl_word_t        ctrl;
	dp_status_t        status;
	logic [IdW-1:0]    out_id;
	logic [TimeW-1:0]  out_time;
	logic              out_drop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_QUANTUM) begin
			quantum_q <= pwdata[QuantW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_QUANTUM) begin
			prdata = 32'(quantum_q);
		end
	end

	assign quantum_eff = (quantum_q == '0) ? QuantW'(1) : quantum_q;
	assign s_tready    = ctrl.in_ready;
	assign m_tdata     = {5'b0, out_drop, out_time, out_id};

	rrct_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	rrct_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.quantum_eff (quantum_eff),
		.in_valid    (s_tvalid),
		.in_burst    (s_tdata),
		.in_last     (s_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_id      (out_id),
		.out_time    (out_time),
		.out_drop    (out_drop),
		.out_last    (m_tlast)
	);

endmodule
`default_nettype wire

>>> sim/rrct_tb_pkg.sv
// Completion-time predictor and result scoreboard for the round-robin completion-time block.
// Depends on rrct_pkg for widths and constants; used by tb_top.
package rrct_tb_pkg;

	import rrct_pkg::*;

	typedef struct {
		logic [IdW-1:0]   process_id;
		logic [TimeW-1:0] completion_time;
		logic             overflowed;
		logic             last_done;
	} completion_t;

	class completion_scoreboard;

		int          remaining [MaxProcs];
		int          loaded;
		bit          dropped;
		int unsigned slice;
		completion_t due_q [$];
		int          errors;

		function new();
			loaded  = 0;
			dropped = 1'b0;
			slice   = QUANTUM_RESET;
			errors  = 0;
		endfunction

		function void set_quantum(logic [QuantW-1:0] value);
			// A zero quantum behaves as a slice of one.
			slice = (value == '0) ? 1 : int'(value);
		endfunction

		function int outstanding();
			return due_q.size();
		endfunction

		// Walks the stored processes in load order and queues one completion per process.
		function void walk_ring();
			int unsigned    elapsed;
			int             ptr;
			bit [MaxProcs-1:0] live;
			completion_t    c;
			elapsed = 0;
			ptr     = 0;
			live    = '0;
			for (int k = 0; k < loaded; k++)
				live[k] = 1'b1;
			while (live != '0) begin
				if (live[ptr]) begin
					if (remaining[ptr] > 0) begin
						remaining[ptr] -= int'(slice);
						elapsed += slice;
						if (elapsed > TIME_MAX)
							elapsed = TIME_MAX;
					end
					if (remaining[ptr] <= 0) begin
						live[ptr]         = 1'b0;
						c.process_id      = IdW'(ptr + 1);
						c.completion_time = TimeW'(elapsed);
						c.overflowed      = dropped;
						c.last_done       = (live == '0);
						due_q.push_back(c);
					end
				end
				ptr = (ptr + 1 < loaded) ? ptr + 1 : 0;
			end
			loaded  = 0;
			dropped = 1'b0;
		endfunction

		function void note_load(logic [BurstW-1:0] burst, logic last_item);
			if (loaded < MaxProcs) begin
				remaining[loaded] = int'(burst);
				loaded++;
			end else begin
				dropped = 1'b1;
			end
			if (last_item)
				walk_ring();
		endfunction

		function void check_completion(logic [31:0] data, logic fin);
			completion_t want;
			if (due_q.size() == 0) begin
				$error("unexpected completion: process_id %0d completion_time %0d",
					data[IdW-1:0], data[IdW +: TimeW]);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (data[IdW-1:0] !== want.process_id) begin
				$error("process_id: expected %0d, got %0d", want.process_id, data[IdW-1:0]);
				errors++;
			end
			if (data[IdW +: TimeW] !== want.completion_time) begin
				$error("completion_time: expected %0d, got %0d", want.completion_time,
					data[IdW +: TimeW]);
				errors++;
			end
			if (data[IdW+TimeW] !== want.overflowed) begin
				$error("overflowed: expected %0d, got %0d", want.overflowed, data[IdW+TimeW]);
				errors++;
			end
			if (fin !== want.last_done) begin
				$error("last_done: expected %0d, got %0d", want.last_done, fin);
				errors++;
			end
		endfunction

	endclass

endpackage

>>> sim/tb_top.sv
// Top-level testbench for round_robin_completion_times_core: drives burst loads and the
// quantum register, and checks every completion against the scoreboard in rrct_tb_pkg.
// Depends on rrct_pkg, rrct_tb_pkg and the block's RTL.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import rrct_pkg::*;
	import rrct_tb_pkg::*;

	localparam int             CYCLE_LIMIT  = 1_500_000;
	localparam int             RANDOM_ITEMS = 280;
	localparam logic [2:0]     QUANTUM_ADDR = {REG_QUANTUM, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	completion_scoreboard sb;
	logic [BurstW-1:0]    run_bursts [$];
	bit                   calm = 1'b0;
	int                   hold_len = 0;
	int                   cycles = 0;

	round_robin_completion_times_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: random back-pressure, with an occasional long hold-off requested by the stimulus.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 18);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_completion(m_tdata, m_tlast);
	end

	task automatic push_burst(input logic [BurstW-1:0] burst, input logic last_item);
		while (!calm && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= burst;
		s_tlast  <= last_item;
		do @(posedge clk); while (!s_tready);
		sb.note_load(burst, last_item);
	endtask

	// Sends the queued bursts as one set; the final transaction carries tlast.
	task automatic send_set();
		foreach (run_bursts[i])
			push_burst(run_bursts[i], i == run_bursts.size() - 1);
	endtask

	task automatic drain_completions(input int tail);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [QuantW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= QUANTUM_ADDR;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_quantum(value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Bursts are mostly kept within a few dozen slices so that small quanta do not make runs long.
	function automatic logic [BurstW-1:0] pick_burst(input int unsigned slice);
		int unsigned roll;
		int unsigned cap;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 12 && slice >= 1000)
			return '1;
		cap = slice * $urandom_range(1, 48);
		if (cap > 65535)
			cap = 65535;
		return BurstW'($urandom_range(0, cap));
	endfunction

	initial begin
		int                random_items;
		int                phase;
		int                runs;
		int                n;
		int unsigned       roll;
		logic [QuantW-1:0] q;
		sb       = new();
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset quantum: the longest burst alone, then zero bursts, an exact fit and an overshoot.
		run_bursts = '{16'hFFFF};
		send_set();
		run_bursts = '{16'd0, 16'd10, 16'd11, 16'd0};
		send_set();
		drain_completions(8);

		// Largest quantum with a full set plus one dropped load that still starts the run.
		write_quantum(10'd1023);
		run_bursts = '{16'hFFFF, 16'd0, 16'd1, 16'd1023, 16'd1024, 16'h8000, 16'd2046,
			16'd2047, 16'h7FFF, 16'd0, 16'h5555, 16'hAAAA, 16'd3000, 16'd1, 16'd4095,
			16'hFFFF, 16'd12345};
		send_set();
		drain_completions(8);

		// A zero quantum behaves as one.
		write_quantum('0);
		run_bursts = '{16'd3, 16'd1};
		send_set();

		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain_completions(8);
			roll = $urandom_range(0, 9);
			case (roll)
				0:       q = 10'd1;
				1:       q = 10'd1023;
				2:       q = '0;
				3:       q = QuantW'($urandom_range(1, 16));
				default: q = QuantW'($urandom_range(1, 1023));
			endcase
			write_quantum(q);
			calm = (phase == 2);
			runs = $urandom_range(2, 4);
			for (int r = 0; r < runs && random_items < RANDOM_ITEMS; r++) begin
				if ($urandom_range(0, 99) < 15)
					n = $urandom_range(17, 22);
				else
					n = $urandom_range(1, 16);
				// Stall the output early so that the walk blocks and the next set waits at the input.
				if (phase == 0 && r == 0) begin
					n        = 20;
					hold_len = 400;
				end
				run_bursts.delete();
				for (int i = 0; i < n; i++)
					run_bursts.push_back(pick_burst(sb.slice));
				send_set();
				random_items += n;
			end
			phase++;
		end
		calm = 1'b0;

		drain_completions(20);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

>>> round_robin_completion_times_core.f
design/rrct_pkg.sv
design/rrct_seq.sv
design/rrct_dp.sv
design/round_robin_completion_times_core.sv
sim/rrct_tb_pkg.sv
sim/tb_top.sv
